/* rtl/jtfe_pkg.sv */
// shared types and constants of the json text field extractor
package jtfe_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CH_LC_X   = 8'h78;

    // key "text" with its quotes
    localparam logic [2:0] KEY_LEN = 3'd6;

    // utf-8 encoding
    localparam logic [15:0] UTF_MAX1  = 16'h007F;
    localparam logic [15:0] UTF_MAX2  = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;

    // configuration
    localparam int          CAP_W     = 13;
    localparam logic [12:0] CAP_RESET = 13'd512;

    // result kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // done status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_KEY  = 2'd1;
    localparam logic [1:0] ST_NOT_STR = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int RES_MAX = 3;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  text_byte;
        logic [1:0]  status;
        logic [11:0] text_length;
        logic        last;
    } res_t;

    // results caused by one request, entries below n are in use
    typedef struct packed {
        logic [1:0]          n;
        res_t [RES_MAX-1:0]  r;
    } res_bundle_t;

endpackage

/* rtl/jtfe_if.sv */
// request and result channel interfaces of the json text field extractor
interface jtfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_body;

    modport source (output valid, output in_byte, output end_of_body, input ready);
    modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

interface jtfe_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  text_byte;
    logic [1:0]  status;
    logic [11:0] text_length;
    logic        last;

    modport source (output valid, output result_kind, output text_byte, output status,
                    output text_length, output last, input ready);
    modport sink   (input valid, input result_kind, input text_byte, input status,
                    input text_length, input last, output ready);
endinterface

/* rtl/json_text_field_extractor.sv */
// top level of the json text field extractor
//
//  channel   direction  handshake          payload
//  in_ch     sink       valid/ready        in_byte, end_of_body
//  out_ch    source     valid/ready        result_kind, text_byte, status, text_length, last
//  config    write      cfg_we             cfg_wdata (text_capacity)
//
// one request taken per cycle while ready; the parser state updates at the accepting edge
// a request yields 0 to 3 results, queued and sent one per cycle while out_ch.ready is high
// in_ch.ready is high while at most one result is queued (four-entry queue)
// a \uXXXX code point of three utf-8 bytes thus holds input while the queue drains
// reset clears parser state and the queue, and sets text_capacity to 512
module json_text_field_extractor
    import jtfe_pkg::*;
#(
    parameter int MAX_TEXT_CAPACITY = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    jtfe_in_if.sink           in_ch,
    jtfe_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata
);

    logic [CAP_W-1:0]  cap_reg;
    logic              room;
    logic              accept;
    res_bundle_t       bundle;
    res_t              head;

    assign in_ch.ready = room;
    assign accept      = in_ch.valid && room;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    jtfe_parser #(
        .MAX_CAP     (MAX_TEXT_CAPACITY)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_ch.in_byte),
        .end_of_body (in_ch.end_of_body),
        .capacity    (cap_reg),
        .bundle      (bundle)
    );

    jtfe_res_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (accept),
        .wr_bundle   (bundle),
        .rd          (out_ch.valid && out_ch.ready),
        .room        (room),
        .not_empty   (out_ch.valid),
        .head        (head)
    );

    // result fields
    assign out_ch.result_kind = head.result_kind;
    assign out_ch.text_byte   = head.text_byte;
    assign out_ch.status      = head.status;
    assign out_ch.text_length = head.text_length;
    assign out_ch.last        = head.last;

endmodule

/* rtl/jtfe_parser.sv */
// byte parser state machine and string decoder, one byte per cycle while accept is high
module jtfe_parser
    import jtfe_pkg::*;
#(
    parameter int MAX_CAP = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              end_of_body,
    input  logic [CAP_W-1:0]  capacity,
    output res_bundle_t       bundle
);

    localparam int CNT_W = (MAX_CAP > 2) ? $clog2(MAX_CAP) : 1;
    localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 2;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_COLON,
        PH_SPACE,
        PH_VALUE,
        PH_ESCAPE,
        PH_HEX,
        PH_CLOSED,
        PH_NOTSTR
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [2:0]         key_idx_reg, key_idx_next;
    logic [1:0]         hex_cnt_reg, hex_cnt_next;
    logic [15:0]        hex_acc_reg, hex_acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [CMP_W-1:0]   cap_x, eff_cap, cnt_x, cnt_new_x;
    logic               fit1, fit2, fit3, fit_nb;
    logic [7:0]         tb [RES_MAX];
    logic [1:0]         ntext;
    logic               done;
    logic [1:0]         done_status;
    logic [4:0]         hex_d;
    logic [15:0]        acc_new;
    logic [7:0]         u0, u1, u2;
    logic [1:0]         nb;
    logic [2:0]         key_idx_cur;
    logic [1:0]         n_all;

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_QUOTE;
            3'd1:    c = CH_LC_T;
            3'd2:    c = CH_LC_E;
            3'd3:    c = CH_LC_X;
            3'd4:    c = CH_LC_T;
            default: c = CH_QUOTE;
        endcase
        return c;
    endfunction

    // valid flag over the digit value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        if (b inside {[8'h30:8'h39]})
            d = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h61:8'h66]})
            d = {1'b1, 4'(b - 8'h57)};
        else if (b inside {[8'h41:8'h46]})
            d = {1'b1, 4'(b - 8'h37)};
        else
            d = 5'd0;
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT)
            || (b == CH_FF) || (b == CH_CR);
    endfunction

    // effective capacity and room checks
    always_comb
    begin
        cap_x = CMP_W'(capacity);
        if (cap_x == '0)
            eff_cap = CMP_W'(1);
        else if (cap_x > CMP_W'(MAX_CAP))
            eff_cap = CMP_W'(MAX_CAP);
        else
            eff_cap = cap_x;
        cnt_x = CMP_W'(cnt_reg);
        fit1  = (cnt_x + CMP_W'(1)) < eff_cap;
        fit2  = (cnt_x + CMP_W'(2)) < eff_cap;
        fit3  = (cnt_x + CMP_W'(3)) < eff_cap;
    end

    // code point to utf-8
    always_comb
    begin
        hex_d   = hex_digit(in_byte);
        acc_new = {hex_acc_reg[11:0], hex_d[3:0]};
        if (acc_new <= UTF_MAX1)
        begin
            nb = 2'd1;
            u0 = acc_new[7:0];
            u1 = 8'h00;
            u2 = 8'h00;
        end
        else if (acc_new <= UTF_MAX2)
        begin
            nb = 2'd2;
            u0 = UTF_LEAD2 | {3'b000, acc_new[10:6]};
            u1 = UTF_CONT | {2'b00, acc_new[5:0]};
            u2 = 8'h00;
        end
        else
        begin
            nb = 2'd3;
            u0 = UTF_LEAD3 | {4'b0000, acc_new[15:12]};
            u1 = UTF_CONT | {2'b00, acc_new[11:6]};
            u2 = UTF_CONT | {2'b00, acc_new[5:0]};
        end
        case (nb)
            2'd1:    fit_nb = fit1;
            2'd2:    fit_nb = fit2;
            default: fit_nb = fit3;
        endcase
    end

    // next state and decoded bytes
    always_comb
    begin
        phase_next   = phase_reg;
        key_idx_next = key_idx_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        tb[0]        = 8'h00;
        tb[1]        = 8'h00;
        tb[2]        = 8'h00;
        ntext        = 2'd0;
        done         = 1'b0;
        key_idx_cur  = (key_idx_reg >= KEY_LEN) ? 3'd0 : key_idx_reg;

        if (end_of_body)
        begin
            done = 1'b1;
            if (phase_reg == PH_ESCAPE)
            begin
                tb[0] = CH_BSLASH;
                ntext = fit1 ? 2'd1 : 2'd0;
            end
            else if (phase_reg == PH_HEX)
            begin
                tb[0] = CH_QMARK;
                ntext = fit1 ? 2'd1 : 2'd0;
            end
            phase_next   = PH_SEARCH;
            key_idx_next = 3'd0;
            hex_cnt_next = 2'd0;
            hex_acc_next = 16'h0000;
        end
        else
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (in_byte == key_char(key_idx_cur))
                    begin
                        if (key_idx_cur == KEY_LEN - 3'd1)
                        begin
                            key_idx_next = 3'd0;
                            phase_next   = PH_COLON;
                        end
                        else
                            key_idx_next = key_idx_cur + 3'd1;
                    end
                    else
                        key_idx_next = (in_byte == CH_QUOTE) ? 3'd1 : 3'd0;
                end
                PH_COLON:
                begin
                    if (in_byte == CH_COLON)
                        phase_next = PH_SPACE;
                end
                PH_SPACE:
                begin
                    if (in_byte == CH_QUOTE)
                        phase_next = PH_VALUE;
                    else if (!is_space(in_byte))
                        phase_next = PH_NOTSTR;
                end
                PH_VALUE:
                begin
                    if (in_byte == CH_QUOTE)
                        phase_next = PH_CLOSED;
                    else if (in_byte == CH_BSLASH)
                        phase_next = PH_ESCAPE;
                    else
                    begin
                        tb[0] = in_byte;
                        ntext = fit1 ? 2'd1 : 2'd0;
                    end
                end
                PH_ESCAPE:
                begin
                    phase_next = PH_VALUE;
                    if (in_byte == CH_LC_U)
                    begin
                        phase_next   = PH_HEX;
                        hex_cnt_next = 2'd0;
                        hex_acc_next = 16'h0000;
                    end
                    else
                    begin
                        if (in_byte == CH_LC_N)
                            tb[0] = CH_LF;
                        else if (in_byte == CH_LC_R)
                            tb[0] = CH_CR;
                        else if (in_byte == CH_LC_T)
                            tb[0] = CH_TAB;
                        else
                            tb[0] = in_byte;
                        ntext = fit1 ? 2'd1 : 2'd0;
                    end
                end
                PH_HEX:
                begin
                    if (hex_d[4])
                    begin
                        if (hex_cnt_reg == 2'd3)
                        begin
                            tb[0]        = u0;
                            tb[1]        = u1;
                            tb[2]        = u2;
                            ntext        = fit_nb ? nb : 2'd0;
                            hex_cnt_next = 2'd0;
                            hex_acc_next = 16'h0000;
                            phase_next   = PH_VALUE;
                        end
                        else
                        begin
                            hex_acc_next = acc_new;
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        // bad digit: '?' then the byte goes through the string rules
                        tb[0]        = CH_QMARK;
                        hex_cnt_next = 2'd0;
                        hex_acc_next = 16'h0000;
                        phase_next   = PH_VALUE;
                        if (in_byte == CH_QUOTE)
                        begin
                            phase_next = PH_CLOSED;
                            ntext      = fit1 ? 2'd1 : 2'd0;
                        end
                        else if (in_byte == CH_BSLASH)
                        begin
                            phase_next = PH_ESCAPE;
                            ntext      = fit1 ? 2'd1 : 2'd0;
                        end
                        else
                        begin
                            tb[1] = in_byte;
                            ntext = fit2 ? 2'd2 : (fit1 ? 2'd1 : 2'd0);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // count and done status
    always_comb
    begin
        cnt_new_x = cnt_x + CMP_W'(ntext);
        if (end_of_body)
            cnt_next = '0;
        else
            cnt_next = cnt_new_x[CNT_W-1:0];
        case (phase_reg)
            PH_SEARCH:                      done_status = ST_NO_KEY;
            PH_COLON, PH_SPACE, PH_NOTSTR:  done_status = ST_NOT_STR;
            default:  done_status = (cnt_new_x != '0) ? ST_OK : ST_EMPTY;
        endcase
    end

    // result bundle
    always_comb
    begin
        n_all    = ntext + 2'(done);
        bundle.n = n_all;
        for (int i = 0; i < RES_MAX; i++)
        begin
            bundle.r[i].result_kind = KIND_TEXT;
            bundle.r[i].text_byte   = tb[i];
            bundle.r[i].status      = ST_OK;
            bundle.r[i].text_length = 12'd0;
            if (done && (2'(i) == ntext))
            begin
                bundle.r[i].result_kind = KIND_DONE;
                bundle.r[i].text_byte   = 8'h00;
                bundle.r[i].status      = done_status;
                bundle.r[i].text_length = cnt_new_x[11:0];
            end
            bundle.r[i].last = (2'(i) == n_all - 2'd1);
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            key_idx_reg <= 3'd0;
            hex_cnt_reg <= 2'd0;
            hex_acc_reg <= 16'h0000;
            cnt_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            key_idx_reg <= key_idx_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

/* rtl/jtfe_res_fifo.sv */
// four-entry result queue, up to three writes and one read per cycle
module jtfe_res_fifo
    import jtfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  res_bundle_t  wr_bundle,
    input  logic         rd,
    output logic         room,
    output logic         not_empty,
    output res_t         head
);

    res_t        mem [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  n_wr;

    assign n_wr      = wr ? wr_bundle.n : 2'd0;
    assign cnt_next  = cnt_reg + 3'(n_wr) - 3'(rd);
    assign room      = (cnt_reg < 3'd2);
    assign not_empty = (cnt_reg != 3'd0);
    assign head      = mem[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_wr;
            rd_ptr_reg <= rd_ptr_reg + 2'(rd);
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (2'(i) < n_wr)
                mem[wr_ptr_reg + 2'(i)] <= wr_bundle.r[i];
        end
    end

endmodule

/* rtl/jtfe_checker.sv */
// port-level checks of the json text field extractor and their binding
module jtfe_checker
    import jtfe_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    jtfe_in_if.sink      in_ch,
    jtfe_out_if.source   out_ch
);

    // a done result always closes the results of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.result_kind == KIND_DONE)) |-> out_ch.last)
        else $error("done result without last");

    // a text byte carries no status and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.result_kind == KIND_TEXT))
        |-> ((out_ch.status == ST_OK) && (out_ch.text_length == 12'd0)))
        else $error("text result with status or length");

    // an accepted end of body always has a result waiting next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.end_of_body) |=> out_ch.valid)
        else $error("end of body gave no result");

    // a stalled result stays valid and holds its byte, kind and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.text_byte)
        && $stable(out_ch.result_kind) && $stable(out_ch.last)))
        else $error("stalled result changed");

endmodule

bind json_text_field_extractor jtfe_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);
